### sv/rta_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rta_pkg
// Types, widths and register codes shared by the box transform block.
// ----------------------------------------------------------------------------
package rta_pkg;

    localparam int COORD_W        = 32;
    localparam int QUAT_W         = 16;
    localparam int QUAT_FRAC_BITS = 15;
    localparam int QPROD_W        = 2 * QUAT_W;
    localparam int ENT_W          = 36;
    localparam int MAT_W          = 19;
    localparam int PROD_W         = MAT_W + COORD_W;
    localparam int ACC_W          = PROD_W + 2;
    localparam int RND_W          = ACC_W - QUAT_FRAC_BITS;
    localparam int TSUM_W         = RND_W + 1;
    localparam int NUM_LANES      = 8;
    localparam int NUM_STAGES     = 6;
    localparam int CFG_IDX_W      = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [QPROD_W-1:0] qprod_t;
    typedef logic signed [ENT_W-1:0]   ent_t;
    typedef logic signed [MAT_W-1:0]   mat_entry_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [RND_W-1:0]   rnd_t;
    typedef logic signed [TSUM_W-1:0]  tsum_t;

    typedef coord_t     [2:0]           vec3_t;
    typedef mat_entry_t [2:0][2:0]      mat_t;
    typedef vec3_t      [NUM_LANES-1:0] lanes_t;

    typedef struct packed {
        vec3_t lo;
        vec3_t hi;
    } box_t;

    typedef struct packed {
        logic prod;
        logic acc;
        logic sat;
        logic pair;
        logic fin;
    } pipe_en_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUAT_X     = 3'd0,
        CFG_QUAT_Y     = 3'd1,
        CFG_QUAT_Z     = 3'd2,
        CFG_QUAT_W     = 3'd3,
        CFG_SHIFT_X    = 3'd4,
        CFG_SHIFT_Y    = 3'd5,
        CFG_SHIFT_Z    = 3'd6,
        CFG_SAME_FRAME = 3'd7
    } cfg_idx_t;

    localparam quat_t QUAT_W_RESET = 16'sh7FFF;
    localparam ent_t  MAT_ONE      = ENT_W'(1) <<< (2 * QUAT_FRAC_BITS);
    localparam ent_t  MAT_HALF     = ENT_W'(1) <<< (QUAT_FRAC_BITS - 1);
    localparam acc_t  ACC_HALF     = ACC_W'(1) <<< (QUAT_FRAC_BITS - 1);
    localparam coord_t COORD_MAX   = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN   = 32'sh8000_0000;

endpackage
`default_nettype wire

### sv/rta_matrix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rta_matrix
// Builds the rotation matrix from the quaternion registers, rounded to Q.15.
// ----------------------------------------------------------------------------
module rta_matrix (
    input  logic          clk,
    input  rta_pkg::quat_t qx,
    input  rta_pkg::quat_t qy,
    input  rta_pkg::quat_t qz,
    input  rta_pkg::quat_t qw,
    output rta_pkg::mat_t  mat
);
    import rta_pkg::*;

    qprod_t xx, yy, zz, xy, xz, yz, wx, wy, wz;
    ent_t [2:0][2:0] ent;
    mat_t mat_reg;

    always_comb
    begin
        xx = qprod_t'(qx) * qprod_t'(qx);
        yy = qprod_t'(qy) * qprod_t'(qy);
        zz = qprod_t'(qz) * qprod_t'(qz);
        xy = qprod_t'(qx) * qprod_t'(qy);
        xz = qprod_t'(qx) * qprod_t'(qz);
        yz = qprod_t'(qy) * qprod_t'(qz);
        wx = qprod_t'(qw) * qprod_t'(qx);
        wy = qprod_t'(qw) * qprod_t'(qy);
        wz = qprod_t'(qw) * qprod_t'(qz);

        ent[0][0] = MAT_ONE - ((ent_t'(yy) + ent_t'(zz)) <<< 1);
        ent[0][1] = (ent_t'(xy) - ent_t'(wz)) <<< 1;
        ent[0][2] = (ent_t'(xz) + ent_t'(wy)) <<< 1;
        ent[1][0] = (ent_t'(xy) + ent_t'(wz)) <<< 1;
        ent[1][1] = MAT_ONE - ((ent_t'(xx) + ent_t'(zz)) <<< 1);
        ent[1][2] = (ent_t'(yz) - ent_t'(wx)) <<< 1;
        ent[2][0] = (ent_t'(xz) - ent_t'(wy)) <<< 1;
        ent[2][1] = (ent_t'(yz) + ent_t'(wx)) <<< 1;
        ent[2][2] = MAT_ONE - ((ent_t'(xx) + ent_t'(yy)) <<< 1);
    end

    // round half up to Q.15
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mat_reg[i][j] <= mat_entry_t'((ent[i][j] + MAT_HALF) >>> QUAT_FRAC_BITS);
            end
        end
    end

    assign mat = mat_reg;

endmodule
`default_nettype wire

### sv/rta_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rta_lane
// Moves one box corner: matrix product, rounding, translation, saturation.
// ----------------------------------------------------------------------------
module rta_lane (
    input  logic              clk,
    input  rta_pkg::mat_t     mat,
    input  rta_pkg::vec3_t    corner,
    input  rta_pkg::vec3_t    shift,
    input  rta_pkg::pipe_en_t en,
    output rta_pkg::vec3_t    moved
);
    import rta_pkg::*;

    prod_t [2:0][2:0] prod_reg;
    rnd_t  [2:0]      rnd_reg;
    vec3_t            moved_reg;
    acc_t  [2:0]      acc_sum;
    tsum_t [2:0]      tsum;

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= mat[i][j] * corner[j];
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_sum[i] = ACC_W'(prod_reg[i][0]) + ACC_W'(prod_reg[i][1])
                       + ACC_W'(prod_reg[i][2]);
            tsum[i]    = TSUM_W'(rnd_reg[i]) + TSUM_W'(shift[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.acc)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rnd_reg[i] <= RND_W'((acc_sum[i] + ACC_HALF) >>> QUAT_FRAC_BITS);
            end
        end
    end

    // clamp when the top bits disagree with the sign
    always_ff @(posedge clk)
    begin
        if (en.sat)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (tsum[i][TSUM_W-1:COORD_W-1] == '0
                    || tsum[i][TSUM_W-1:COORD_W-1] == '1)
                begin
                    moved_reg[i] <= tsum[i][COORD_W-1:0];
                end
                else if (tsum[i][TSUM_W-1])
                begin
                    moved_reg[i] <= COORD_MIN;
                end
                else
                begin
                    moved_reg[i] <= COORD_MAX;
                end
            end
        end
    end

    assign moved = moved_reg;

endmodule
`default_nettype wire

### sv/rta_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rta_merge
// Folds the eight moved corners into one box, or selects the bypass box when same_frame is set.
// ----------------------------------------------------------------------------
module rta_merge (
    input  logic              clk,
    input  rta_pkg::lanes_t   moved,
    input  rta_pkg::box_t     bypass,
    input  logic              same_frame,
    input  rta_pkg::pipe_en_t en,
    output rta_pkg::box_t     box
);
    import rta_pkg::*;

    vec3_t [1:0] half_min, half_max;
    vec3_t [1:0] half_min_reg, half_max_reg;
    box_t        fold;
    box_t        box_reg;

    // each half covers four lanes
    always_comb
    begin
        for (int h = 0; h < 2; h++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                half_min[h][i] = moved[4 * h][i];
                half_max[h][i] = moved[4 * h][i];
                for (int k = 1; k < 4; k++)
                begin
                    if (moved[4 * h + k][i] < half_min[h][i])
                    begin
                        half_min[h][i] = moved[4 * h + k][i];
                    end
                    if (moved[4 * h + k][i] > half_max[h][i])
                    begin
                        half_max[h][i] = moved[4 * h + k][i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.pair)
        begin
            half_min_reg <= half_min;
            half_max_reg <= half_max;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fold.lo[i] = (half_min_reg[1][i] < half_min_reg[0][i])
                       ? half_min_reg[1][i] : half_min_reg[0][i];
            fold.hi[i] = (half_max_reg[1][i] > half_max_reg[0][i])
                       ? half_max_reg[1][i] : half_max_reg[0][i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.fin)
        begin
            box_reg <= same_frame ? bypass : fold;
        end
    end

    assign box = box_reg;

endmodule
`default_nettype wire

### sv/rigid_transform_aabb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rigid_transform_aabb_top
// Rigid transform of an axis-aligned box: rotate, translate, re-bound.
// ----------------------------------------------------------------------------
// Takes one box per clock cycle while in_stall is low and returns one box per
// request after six register stages; stages may hold while the output stalls.
// Eight corner lanes work side by side, each with its own three multipliers
// per axis, and a two-stage min/max tree merges them; the rate is set by that
// fully pipelined lane datapath. A quaternion write is registered first in the
// quaternion register and then in the matrix register. Stages hold independently,
// so the input keeps taking requests into empty stages while a finished result
// waits at the output.
module rigid_transform_aabb_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rta_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rta_pkg::COORD_W-1:0]      cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  rta_pkg::coord_t                  in_min_x,
    input  rta_pkg::coord_t                  in_min_y,
    input  rta_pkg::coord_t                  in_min_z,
    input  rta_pkg::coord_t                  in_max_x,
    input  rta_pkg::coord_t                  in_max_y,
    input  rta_pkg::coord_t                  in_max_z,
    output logic                             out_valid,
    input  logic                             out_stall,
    output rta_pkg::coord_t                  out_min_x,
    output rta_pkg::coord_t                  out_min_y,
    output rta_pkg::coord_t                  out_min_z,
    output rta_pkg::coord_t                  out_max_x,
    output rta_pkg::coord_t                  out_max_y,
    output rta_pkg::coord_t                  out_max_z
);
    import rta_pkg::*;

    quat_t  quat_x_reg, quat_y_reg, quat_z_reg, quat_w_reg;
    vec3_t  shift_reg;
    logic   same_frame_reg;

    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    logic [NUM_STAGES-1:0] adv, up, ld;
    pipe_en_t              en;

    box_t   [NUM_STAGES-2:0] box_reg;
    box_t   in_box, out_box;
    mat_t   mat;
    lanes_t corner, moved;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_x_reg     <= '0;
            quat_y_reg     <= '0;
            quat_z_reg     <= '0;
            quat_w_reg     <= QUAT_W_RESET;
            shift_reg      <= '0;
            same_frame_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_QUAT_X:     quat_x_reg     <= cfg_data[QUAT_W-1:0];
                CFG_QUAT_Y:     quat_y_reg     <= cfg_data[QUAT_W-1:0];
                CFG_QUAT_Z:     quat_z_reg     <= cfg_data[QUAT_W-1:0];
                CFG_QUAT_W:     quat_w_reg     <= cfg_data[QUAT_W-1:0];
                CFG_SHIFT_X:    shift_reg[0]   <= cfg_data;
                CFG_SHIFT_Y:    shift_reg[1]   <= cfg_data;
                CFG_SHIFT_Z:    shift_reg[2]   <= cfg_data;
                CFG_SAME_FRAME: same_frame_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // stage hand-off: a stage advances when empty or when its successor does
    always_comb
    begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        up       = {vld_reg[NUM_STAGES-2:0], in_valid};
        ld       = adv & up;
        vld_next = ld | (~adv & vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign en.prod = ld[1];
    assign en.acc  = ld[2];
    assign en.sat  = ld[3];
    assign en.pair = ld[4];
    assign en.fin  = ld[5];

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NUM_STAGES-1];

    assign in_box.lo[0] = in_min_x;
    assign in_box.lo[1] = in_min_y;
    assign in_box.lo[2] = in_min_z;
    assign in_box.hi[0] = in_max_x;
    assign in_box.hi[1] = in_max_y;
    assign in_box.hi[2] = in_max_z;

    // carry the request box alongside the lanes for the bypass
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            box_reg[0] <= in_box;
        end
        for (int k = 1; k < NUM_STAGES - 1; k++)
        begin
            if (ld[k])
            begin
                box_reg[k] <= box_reg[k-1];
            end
        end
    end

    rta_matrix u_matrix (
        .clk (clk),
        .qx  (quat_x_reg),
        .qy  (quat_y_reg),
        .qz  (quat_z_reg),
        .qw  (quat_w_reg),
        .mat (mat)
    );

    for (genvar c = 0; c < NUM_LANES; c++)
    begin : g_lane
        assign corner[c][0] = ((c & 4) != 0) ? box_reg[0].hi[0] : box_reg[0].lo[0];
        assign corner[c][1] = ((c & 2) != 0) ? box_reg[0].hi[1] : box_reg[0].lo[1];
        assign corner[c][2] = ((c & 1) != 0) ? box_reg[0].hi[2] : box_reg[0].lo[2];

        rta_lane u_lane (
            .clk    (clk),
            .mat    (mat),
            .corner (corner[c]),
            .shift  (shift_reg),
            .en     (en),
            .moved  (moved[c])
        );
    end

    rta_merge u_merge (
        .clk        (clk),
        .moved      (moved),
        .bypass     (box_reg[NUM_STAGES-2]),
        .same_frame (same_frame_reg),
        .en         (en),
        .box        (out_box)
    );

    assign out_min_x = out_box.lo[0];
    assign out_min_y = out_box.lo[1];
    assign out_min_z = out_box.lo[2];
    assign out_max_x = out_box.hi[0];
    assign out_max_y = out_box.hi[1];
    assign out_max_z = out_box.hi[2];

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> vld_reg[0])
        else $error("input stalled with an empty first stage");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted request lost at the first stage");

    a_merge_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NUM_STAGES-2] && !vld_reg[NUM_STAGES-1]) |=> vld_reg[NUM_STAGES-1])
        else $error("merge stage failed to move into an empty output stage");
`endif

endmodule
`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Box transform bench: boxes are pushed through random and corner-case frames,
// and every result box is checked against a bit-exact fixed-point predictor.
// The input side idles and the output side stalls at random.
// ----------------------------------------------------------------------------
module tb;
    import rta_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RAND_PHASES   = 10;
    localparam int RAND_PER_PHASE = 103;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]   cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    logic                 out_stall = 1'b1;
    coord_t               out_min_x, out_min_y, out_min_z;
    coord_t               out_max_x, out_max_y, out_max_z;

    box_t req_box = '0;
    box_t got_box;
    box_t due_box;

    // frame currently loaded into the block
    quat_t  rot_x = '0;
    quat_t  rot_y = '0;
    quat_t  rot_z = '0;
    quat_t  rot_w = QUAT_W_RESET;
    coord_t shift_v [3] = '{default: '0};
    logic   pass_through = 1'b0;

    box_t  boxes_to_send [$];
    box_t  bounds_due [$];
    string axis_tag [3] = '{"x", "y", "z"};

    logic req_taken;
    logic bound_taken;
    int   send_wait = 0;
    bit   send_calm = 1'b0;
    int   hold_left = 3;
    bit   recv_calm = 1'b0;
    int   mismatch_count = 0;
    int   cycle_count = 0;

    rigid_transform_aabb_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_min_x  (req_box.lo[0]),
        .in_min_y  (req_box.lo[1]),
        .in_min_z  (req_box.lo[2]),
        .in_max_x  (req_box.hi[0]),
        .in_max_y  (req_box.hi[1]),
        .in_max_z  (req_box.hi[2]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_min_x (out_min_x),
        .out_min_y (out_min_y),
        .out_min_z (out_min_z),
        .out_max_x (out_max_x),
        .out_max_y (out_max_y),
        .out_max_z (out_max_z)
    );

    assign got_box = {out_min_z, out_min_y, out_min_x, out_max_z, out_max_y, out_max_x};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // round half up from 2F to F fraction bits, floor on the shift
    function automatic longint round_q(longint v);
        return (v + (longint'(1) <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
    endfunction

    function automatic box_t transform_box(box_t b);
        longint x, y, z, w, unit_sq, acc, moved;
        longint rot [3][3];
        longint corner [3];
        longint lo_b [3];
        longint hi_b [3];
        box_t   res;
        if (pass_through)
            return b;
        x = rot_x;
        y = rot_y;
        z = rot_z;
        w = rot_w;
        unit_sq = longint'(1) <<< (2 * QUAT_FRAC_BITS);
        rot[0][0] = round_q(unit_sq - 2 * (y * y + z * z));
        rot[0][1] = round_q(2 * (x * y - w * z));
        rot[0][2] = round_q(2 * (x * z + w * y));
        rot[1][0] = round_q(2 * (x * y + w * z));
        rot[1][1] = round_q(unit_sq - 2 * (x * x + z * z));
        rot[1][2] = round_q(2 * (y * z - w * x));
        rot[2][0] = round_q(2 * (x * z - w * y));
        rot[2][1] = round_q(2 * (y * z + w * x));
        rot[2][2] = round_q(unit_sq - 2 * (x * x + y * y));
        for (int c = 0; c < 8; c++)
        begin
            corner[0] = (c & 4) ? b.hi[0] : b.lo[0];
            corner[1] = (c & 2) ? b.hi[1] : b.lo[1];
            corner[2] = (c & 1) ? b.hi[2] : b.lo[2];
            for (int i = 0; i < 3; i++)
            begin
                acc = rot[i][0] * corner[0] + rot[i][1] * corner[1]
                    + rot[i][2] * corner[2];
                moved = round_q(acc) + shift_v[i];
                if (moved > longint'(COORD_MAX))
                    moved = longint'(COORD_MAX);
                if (moved < longint'(COORD_MIN))
                    moved = longint'(COORD_MIN);
                if (c == 0 || moved < lo_b[i])
                    lo_b[i] = moved;
                if (c == 0 || moved > hi_b[i])
                    hi_b[i] = moved;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            res.lo[i] = coord_t'(lo_b[i]);
            res.hi[i] = coord_t'(hi_b[i]);
        end
        return res;
    endfunction

    function automatic int pick_wait();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 3);
    endfunction

    function automatic coord_t edge_coord();
        case ($urandom_range(0, 4))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic box_t random_box();
        box_t b;
        int   kind;
        int   centre;
        int   half;
        kind = $urandom_range(0, 19);
        for (int i = 0; i < 3; i++)
        begin
            if (kind < 14)
            begin
                // well-formed box, magnitudes spread over many octaves
                centre = int'($urandom) >>> $urandom_range(2, 14);
                half = int'($urandom_range(0, 32'h00FF_FFFF)) >>> $urandom_range(0, 12);
                b.lo[i] = centre - half;
                b.hi[i] = centre + half;
            end
            else if (kind < 17)
            begin
                b.lo[i] = $urandom;
                b.hi[i] = $urandom;
            end
            else
            begin
                b.lo[i] = edge_coord();
                b.hi[i] = edge_coord();
            end
        end
        return b;
    endfunction

    task automatic flag_error(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (boxes_to_send.size() != 0 || in_valid || bounds_due.size() != 0);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [COORD_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_QUAT_X:     rot_x = data[QUAT_W-1:0];
            CFG_QUAT_Y:     rot_y = data[QUAT_W-1:0];
            CFG_QUAT_Z:     rot_z = data[QUAT_W-1:0];
            CFG_QUAT_W:     rot_w = data[QUAT_W-1:0];
            CFG_SHIFT_X:    shift_v[0] = data;
            CFG_SHIFT_Y:    shift_v[1] = data;
            CFG_SHIFT_Z:    shift_v[2] = data;
            CFG_SAME_FRAME: pass_through = data[0];
            default: ;
        endcase
    endtask

    // unused upper bits of the narrow registers carry junk
    task automatic load_frame(quat_t qx, quat_t qy, quat_t qz, quat_t qw,
                              coord_t sx, coord_t sy, coord_t sz, bit pass);
        wait_idle();
        write_reg(CFG_QUAT_X, {16'($urandom), qx});
        write_reg(CFG_QUAT_Y, {16'($urandom), qy});
        write_reg(CFG_QUAT_Z, {16'($urandom), qz});
        write_reg(CFG_QUAT_W, {16'($urandom), qw});
        write_reg(CFG_SHIFT_X, sx);
        write_reg(CFG_SHIFT_Y, sy);
        write_reg(CFG_SHIFT_Z, sz);
        write_reg(CFG_SAME_FRAME, {31'($urandom), pass});
        @(negedge clk);
        cfg_we <= 1'b0;
        // let the quaternion reach the matrix register
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic random_frame();
        int     comp [4];
        quat_t  q [4];
        coord_t sh [3];
        real    norm;
        int     kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 4; i++)
            comp[i] = int'($urandom_range(0, 65535)) - 32768;
        norm = $sqrt(real'(comp[0]) * real'(comp[0]) + real'(comp[1]) * real'(comp[1])
                   + real'(comp[2]) * real'(comp[2]) + real'(comp[3]) * real'(comp[3]));
        for (int i = 0; i < 4; i++)
        begin
            if (kind < 6 && norm >= 1.0)
                q[i] = quat_t'($rtoi(real'(comp[i]) * 32767.0 / norm));
            else if (kind < 8)
                q[i] = quat_t'(comp[i]);
            else
                case ($urandom_range(0, 2))
                    0: q[i] = '0;
                    1: q[i] = 16'sh7FFF;
                    default: q[i] = 16'sh8000;
                endcase
        end
        for (int i = 0; i < 3; i++)
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: sh[i] = int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
                5, 6, 7: sh[i] = $urandom;
                8: sh[i] = COORD_MAX;
                default: sh[i] = COORD_MIN;
            endcase
        load_frame(q[0], q[1], q[2], q[3], sh[0], sh[1], sh[2], $urandom_range(0, 7) == 0);
    endtask

    task automatic queue_directed();
        box_t b;
        b = '0;
        boxes_to_send = {boxes_to_send, b};
        b.lo = {3{COORD_MIN}};
        b.hi = {3{COORD_MAX}};
        boxes_to_send = {boxes_to_send, b};
        // inverted box, every min above its max
        b.lo = {3{COORD_MAX}};
        b.hi = {3{COORD_MIN}};
        boxes_to_send = {boxes_to_send, b};
        b.lo = {3{32'hAAAA_AAAA}};
        b.hi = {3{32'h5555_5555}};
        boxes_to_send = {boxes_to_send, b};
        b.lo = {32'sh0003_0000, -32'sh0001_0000, -32'sh0000_8000};
        b.hi = {32'sh0005_0000, 32'sh0001_0000, 32'sh0000_8000};
        boxes_to_send = {boxes_to_send, b};
    endtask

    // driver: present the next box after its drawn idle gap, hold while stalled
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !req_taken))
        begin
            if (send_wait > 0)
            begin
                send_wait--;
                in_valid <= 1'b0;
            end
            else if (boxes_to_send.size() != 0)
            begin
                req_box <= boxes_to_send.pop_front();
                in_valid <= 1'b1;
                if ($urandom_range(0, 49) == 0)
                    send_calm = !send_calm;
                send_wait = send_calm ? 0 : pick_wait();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side: stall each result for a drawn number of cycles
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (bound_taken)
            begin
                if ($urandom_range(0, 49) == 0)
                    recv_calm = !recv_calm;
                hold_left = recv_calm ? 0 : pick_wait();
            end
            if (hold_left > 0)
            begin
                if (out_valid)
                    hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_taken <= 1'b0;
            bound_taken <= 1'b0;
        end
        else
        begin
            req_taken <= in_valid && !in_stall;
            bound_taken <= out_valid && !out_stall;
            if (in_valid && !in_stall)
                bounds_due = {bounds_due, transform_box(req_box)};
            if (out_valid && !out_stall)
            begin
                if (bounds_due.size() == 0)
                    flag_error("result with no request outstanding");
                else
                begin
                    due_box = bounds_due.pop_front();
                    for (int i = 0; i < 3; i++)
                    begin
                        if (got_box.lo[i] !== due_box.lo[i])
                            flag_error($sformatf("out_min_%s expected %0d, got %0d",
                                axis_tag[i], due_box.lo[i], got_box.lo[i]));
                        if (got_box.hi[i] !== due_box.hi[i])
                            flag_error($sformatf("out_max_%s expected %0d, got %0d",
                                axis_tag[i], due_box.hi[i], got_box.hi[i]));
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // frame as left by reset
        queue_directed();
        // quarter turn about z, translation at the extremes
        load_frame('0, '0, 16'sd23170, 16'sd23170, COORD_MAX, COORD_MIN, '0, 1'b0);
        queue_directed();
        // all-zero quaternion behaves as identity
        load_frame('0, '0, '0, '0, 32'sh0003_0000, -32'sh0002_8000, 32'sh0000_0001, 1'b0);
        queue_directed();
        // far from unit length: rotation scales as well
        load_frame(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                   COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_directed();
        // bypass ignores the loaded rotation and shift
        load_frame(16'sh7FFF, 16'sh8000, 16'sh1234, '0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        queue_directed();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            random_frame();
            for (int n = 0; n < RAND_PER_PHASE; n++)
                boxes_to_send = {boxes_to_send, random_box()};
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && bounds_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
sv/rta_pkg.sv
sv/rta_matrix.sv
sv/rta_lane.sv
sv/rta_merge.sv
sv/rigid_transform_aabb_top.sv
tb/tb.sv
